// ===== sv/spmcf_pkg.sv =====
// Package: constants, types and FSM state for the strict-priority multi-class FIFO.
`timescale 1ns / 1ps

package spmcf_pkg;

  localparam int CLASSES    = 4;
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 64;

  // Fixed port field widths
  localparam int PORT_CLASS_W = 2;
  localparam int PORT_DATA_W  = 64;
  localparam int PORT_TOTAL_W = 7;

  // Derived internal widths
  localparam int CLS_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TOT_W  = $clog2(CLASSES * DEPTH + 1);
  localparam int ADDR_W = $clog2(CLASSES * DEPTH);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== sv/spmcf_if.sv =====
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps

interface spmcf_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [spmcf_pkg::PORT_CLASS_W-1:0] class_id;
  logic [spmcf_pkg::PORT_DATA_W-1:0]  item_data;

  modport source (output valid, kind, class_id, item_data, input ready);
  modport sink   (input valid, kind, class_id, item_data, output ready);
endinterface

interface spmcf_out_if;
  logic                               valid;
  logic                               ready;
  logic                               pop_valid;
  logic [spmcf_pkg::PORT_CLASS_W-1:0] pop_class;
  logic [spmcf_pkg::PORT_DATA_W-1:0]  pop_data;
  logic                               push_full;
  logic [spmcf_pkg::PORT_TOTAL_W-1:0] total_count;

  modport source (output valid, pop_valid, pop_class, pop_data, push_full, total_count,
                  input ready);
  modport sink   (input valid, pop_valid, pop_class, pop_data, push_full, total_count,
                  output ready);
endinterface

// ===== sv/spmcf_ctrl.sv =====
// Controller state machine: accept, execute, load result.
`timescale 1ns / 1ps

module spmcf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spmcf_pkg::status_t status,
  output spmcf_pkg::cmd_t    cmd
);

  spmcf_pkg::state_t state_r;
  spmcf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spmcf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spmcf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = spmcf_pkg::ST_EXEC;
      end
      spmcf_pkg::ST_EXEC: begin
        state_nxt = spmcf_pkg::ST_LOAD;
      end
      spmcf_pkg::ST_LOAD: begin
        if (status.out_free) state_nxt = spmcf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = spmcf_pkg::ST_IDLE;
      end
    endcase
  end

  // no transfer is taken while reset is held
  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    cmd.load   = 1'b0;
    case (state_r)
      spmcf_pkg::ST_IDLE: begin
        in_ready   = rst_n;
        cmd.accept = rst_n && in_valid;
      end
      spmcf_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      spmcf_pkg::ST_LOAD: begin
        cmd.load = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/spmcf_dpath.sv =====
// Datapath: ring store, per-class indices and counts, result register.
`timescale 1ns / 1ps

module spmcf_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  spmcf_pkg::cmd_t                    cmd,
  output spmcf_pkg::status_t                 status,
  input  logic                               in_kind,
  input  logic [spmcf_pkg::PORT_CLASS_W-1:0] in_class_id,
  input  logic [spmcf_pkg::PORT_DATA_W-1:0]  in_item_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_pop_valid,
  output logic [spmcf_pkg::PORT_CLASS_W-1:0] out_pop_class,
  output logic [spmcf_pkg::PORT_DATA_W-1:0]  out_pop_data,
  output logic                               out_push_full,
  output logic [spmcf_pkg::PORT_TOTAL_W-1:0] out_total_count
);

  localparam int CLASSES = spmcf_pkg::CLASSES;
  localparam int DEPTH   = spmcf_pkg::DEPTH;
  localparam int DW      = spmcf_pkg::DATA_WIDTH;
  localparam int CLS_W   = spmcf_pkg::CLS_W;
  localparam int IDX_W   = spmcf_pkg::IDX_W;
  localparam int CNT_W   = spmcf_pkg::CNT_W;
  localparam int TOT_W   = spmcf_pkg::TOT_W;
  localparam int ADDR_W  = spmcf_pkg::ADDR_W;

  // Latched item
  logic                               kind_r;
  logic [spmcf_pkg::PORT_CLASS_W-1:0] cls_r;
  logic [DW-1:0]                      data_r;

  // Queue state
  logic [IDX_W-1:0] rd_idx_r [CLASSES];
  logic [IDX_W-1:0] wr_idx_r [CLASSES];
  logic [CNT_W-1:0] cnt_r    [CLASSES];
  logic [TOT_W-1:0] total_r;

  logic [DW-1:0] mem [CLASSES * DEPTH];
  logic [DW-1:0] rdata_r;

  // Result flags from the execute step
  logic             res_valid_r;
  logic [CLS_W-1:0] res_class_r;
  logic             res_full_r;

  // Output register
  logic                               out_valid_r;
  logic                               out_pop_valid_r;
  logic [spmcf_pkg::PORT_CLASS_W-1:0] out_pop_class_r;
  logic [spmcf_pkg::PORT_DATA_W-1:0]  out_pop_data_r;
  logic                               out_push_full_r;
  logic [spmcf_pkg::PORT_TOTAL_W-1:0] out_total_r;

  logic             cls_ok;
  logic [CLS_W-1:0] cls_idx;
  logic             push_ok;
  logic             pop_found;
  logic [CLS_W-1:0] pop_sel;
  logic             do_push;
  logic             do_pop;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  assign cls_ok  = int'(cls_r) < CLASSES;
  assign cls_idx = CLS_W'(cls_r);
  assign push_ok = cls_ok && (cnt_r[cls_idx] < CNT_W'(DEPTH));

  // Lowest-numbered non-empty class wins
  always_comb begin
    pop_found = 1'b0;
    pop_sel   = '0;
    for (int c = CLASSES - 1; c >= 0; c--) begin
      if (cnt_r[c] != '0) begin
        pop_found = 1'b1;
        pop_sel   = CLS_W'(c);
      end
    end
  end

  assign do_push = cmd.exec && (kind_r == spmcf_pkg::KIND_PUSH) && push_ok;
  assign do_pop  = cmd.exec && (kind_r == spmcf_pkg::KIND_POP) && pop_found;
  assign waddr   = ADDR_W'(int'(cls_idx) * DEPTH + int'(wr_idx_r[cls_idx]));
  assign raddr   = ADDR_W'(int'(pop_sel) * DEPTH + int'(rd_idx_r[pop_sel]));

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      cls_r  <= in_class_id;
      data_r <= in_item_data[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[waddr] <= data_r;
    end
    if (cmd.exec) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_valid_r <= (kind_r == spmcf_pkg::KIND_POP) && pop_found;
      res_class_r <= pop_sel;
      res_full_r  <= (kind_r == spmcf_pkg::KIND_PUSH) && !push_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASSES; c++) begin
        rd_idx_r[c] <= '0;
        wr_idx_r[c] <= '0;
        cnt_r[c]    <= '0;
      end
      total_r <= '0;
    end else if (do_push) begin
      wr_idx_r[cls_idx] <= (wr_idx_r[cls_idx] == IDX_W'(DEPTH - 1)) ? '0
                           : wr_idx_r[cls_idx] + 1'b1;
      cnt_r[cls_idx]    <= cnt_r[cls_idx] + 1'b1;
      total_r           <= total_r + 1'b1;
    end else if (do_pop) begin
      rd_idx_r[pop_sel] <= (rd_idx_r[pop_sel] == IDX_W'(DEPTH - 1)) ? '0
                           : rd_idx_r[pop_sel] + 1'b1;
      cnt_r[pop_sel]    <= cnt_r[pop_sel] - 1'b1;
      total_r           <= total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_pop_valid_r <= res_valid_r;
      out_pop_class_r <= res_valid_r ? spmcf_pkg::PORT_CLASS_W'(res_class_r) : '0;
      out_pop_data_r  <= res_valid_r ? spmcf_pkg::PORT_DATA_W'(rdata_r) : '0;
      out_push_full_r <= res_full_r;
      out_total_r     <= spmcf_pkg::PORT_TOTAL_W'(total_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pop_valid   = out_pop_valid_r;
  assign out_pop_class   = out_pop_class_r;
  assign out_pop_data    = out_pop_data_r;
  assign out_push_full   = out_push_full_r;
  assign out_total_count = out_total_r;

endmodule

// ===== sv/strict_priority_multi_class_fifo.sv =====
// Top level: strict-priority multi-class FIFO with valid/ready channels.
//
// in_ch carries one item per transfer: kind 0 pushes item_data into class
// class_id, kind 1 pops the oldest word of the lowest-numbered non-empty
// class. out_ch carries exactly one result per item: pop_valid, pop_class,
// pop_data, push_full and the total occupancy after the item.
// A push into a full or nonexistent class is dropped with push_full set;
// a pop with every class empty returns pop_valid low and zero fields.
// A result passes two registered steps after its input transfer: the
// execute step updates the per-class indices and reads the ring store
// (registered read), then the load step fills the result register.
// A new item is taken only in the idle state, after the load step.
// If out_ch stalls, the block holds one finished result in its output
// register, executes the following item, then waits before loading it.
// Synchronous reset empties every class and drops any pending result;
// in_ready stays low while reset is held; store contents are not cleared.
`timescale 1ns / 1ps

module strict_priority_multi_class_fifo (
  input  logic              clk,
  input  logic              rst_n,
  spmcf_in_if.sink          in_ch,
  spmcf_out_if.source       out_ch
);

  spmcf_pkg::cmd_t    cmd;
  spmcf_pkg::status_t status;

  spmcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  spmcf_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_ch.kind),
    .in_class_id     (in_ch.class_id),
    .in_item_data    (in_ch.item_data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_pop_valid   (out_ch.pop_valid),
    .out_pop_class   (out_ch.pop_class),
    .out_pop_data    (out_ch.pop_data),
    .out_push_full   (out_ch.push_full),
    .out_total_count (out_ch.total_count)
  );

endmodule

// ===== tb/sv/tb_strict_priority_multi_class_fifo.sv =====
// Self-checking testbench for the strict-priority multi-class FIFO.
`timescale 1ns / 1ps

module tb_strict_priority_multi_class_fifo;

  localparam int CLASSES      = spmcf_pkg::CLASSES;
  localparam int DEPTH        = spmcf_pkg::DEPTH;
  localparam int DATA_WIDTH   = spmcf_pkg::DATA_WIDTH;
  localparam int IDX_W        = spmcf_pkg::IDX_W;
  localparam int CNT_W        = spmcf_pkg::CNT_W;
  localparam int PORT_CLASS_W = spmcf_pkg::PORT_CLASS_W;
  localparam int PORT_DATA_W  = spmcf_pkg::PORT_DATA_W;
  localparam int PORT_TOTAL_W = spmcf_pkg::PORT_TOTAL_W;

  localparam int RAND_ITEMS   = 1725;
  localparam int SEG_LEN      = 80;
  localparam int MAX_WAIT     = 14;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_COUNT   = 2;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic                    kind;
    logic [PORT_CLASS_W-1:0] class_id;
    logic [PORT_DATA_W-1:0]  item_data;
    int                      gap;
  } fifo_item_t;

  typedef struct packed {
    logic                    pop_valid;
    logic [PORT_CLASS_W-1:0] pop_class;
    logic [PORT_DATA_W-1:0]  pop_data;
    logic                    push_full;
    logic [PORT_TOTAL_W-1:0] total_count;
  } fifo_result_t;

  logic clk;
  logic rst_n;

  spmcf_in_if  in_ch ();
  spmcf_out_if out_ch ();

  strict_priority_multi_class_fifo uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the per-class rings
  logic [DATA_WIDTH-1:0] mirror_store [CLASSES][DEPTH];
  logic [IDX_W-1:0]      mirror_rd    [CLASSES];
  logic [IDX_W-1:0]      mirror_wr    [CLASSES];
  logic [CNT_W-1:0]      mirror_fill  [CLASSES];

  fifo_item_t   pending_items[$];
  fifo_result_t expected_results[$];

  int   cycle_cnt    = 0;
  int   accepted_cnt = 0;
  int   total_items  = 0;
  int   errors       = 0;
  logic in_taken     = 1'b0;
  logic res_taken    = 1'b0;
  logic hold_off     = 1'b0;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic fifo_result_t priority_fifo_step(input fifo_item_t it);
    fifo_result_t r;
    int unsigned  occ;
    bit           found;
    r     = '0;
    occ   = 0;
    found = 1'b0;
    if (it.kind == spmcf_pkg::KIND_PUSH) begin
      if (it.class_id >= CLASSES || mirror_fill[it.class_id] >= DEPTH) begin
        r.push_full = 1'b1;
      end else begin
        mirror_store[it.class_id][mirror_wr[it.class_id]] = it.item_data[DATA_WIDTH-1:0];
        mirror_wr[it.class_id]   = ring_next(mirror_wr[it.class_id]);
        mirror_fill[it.class_id] = mirror_fill[it.class_id] + 1'b1;
      end
    end else begin
      for (int c = 0; c < CLASSES; c++) begin
        if (!found && mirror_fill[c] != 0) begin
          found       = 1'b1;
          r.pop_valid = 1'b1;
          r.pop_class = PORT_CLASS_W'(c);
          r.pop_data  = PORT_DATA_W'(mirror_store[c][mirror_rd[c]]);
          mirror_rd[c]   = ring_next(mirror_rd[c]);
          mirror_fill[c] = mirror_fill[c] - 1'b1;
        end
      end
    end
    for (int c = 0; c < CLASSES; c++) occ += mirror_fill[c];
    r.total_count = PORT_TOTAL_W'(occ);
    return r;
  endfunction

  function automatic logic [PORT_DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_item(input logic kind, input int cls, input logic [PORT_DATA_W-1:0] data,
                          input int gap);
    fifo_item_t it;
    it.kind      = kind;
    it.class_id  = PORT_CLASS_W'(cls);
    it.item_data = data;
    it.gap       = gap;
    pending_items.push_back(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // driver
  fifo_item_t next_item;
  logic       next_loaded = 1'b0;
  int         send_gap    = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      next_loaded = 1'b0;
      send_gap    = 0;
    end else if (!in_ch.valid || in_taken) begin
      if (!next_loaded && pending_items.size() != 0) begin
        next_item   = pending_items.pop_front();
        send_gap    = next_item.gap;
        next_loaded = 1'b1;
      end
      if (next_loaded && send_gap == 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= next_item.kind;
        in_ch.class_id  <= next_item.class_id;
        in_ch.item_data <= next_item.item_data;
        next_loaded = 1'b0;
      end else begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  int   take_wait    = 0;
  int   results_seen = 0;
  logic rx_idle_mode = 1'b1;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (res_taken) begin
        results_seen++;
        if (results_seen % 64 == 0) rx_idle_mode = ($urandom_range(0, 3) != 0);
        take_wait = rx_idle_mode ? $urandom_range(0, MAX_WAIT) : 0;
      end else if (take_wait > 0) begin
        take_wait--;
      end
      out_ch.ready <= (take_wait == 0) && !hold_off;
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    for (int k = 0; k < HOLD_COUNT; k++) begin
      wait (accepted_cnt >= 300 + k * 800);
      @(negedge clk) hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_off <= 1'b0;
    end
  end

  // monitor: checks result transfers, predicts on input transfers
  always @(posedge clk) begin
    fifo_result_t got;
    fifo_result_t want;
    fifo_item_t   taken;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_taken <= 1'b1;
      got = '{out_ch.pop_valid, out_ch.pop_class, out_ch.pop_data, out_ch.push_full,
              out_ch.total_count};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result at cycle %0d: %p", cycle_cnt, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"mismatch at cycle %0d: expected valid=%0b class=%0d data=%h full=%0b ",
                      "total=%0d, got valid=%0b class=%0d data=%h full=%0b total=%0d"},
                     cycle_cnt, want.pop_valid, want.pop_class, want.pop_data, want.push_full,
                     want.total_count, got.pop_valid, got.pop_class, got.pop_data,
                     got.push_full, got.total_count);
        end
      end
    end else begin
      res_taken <= 1'b0;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      taken.kind      = in_ch.kind;
      taken.class_id  = in_ch.class_id;
      taken.item_data = in_ch.item_data;
      taken.gap       = 0;
      expected_results.push_back(priority_fifo_step(taken));
      in_taken     <= 1'b1;
      accepted_cnt <= accepted_cnt + 1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  initial begin
    int push_pct;
    int focus_cls;
    bit focused;
    bit idle_seg;
    int cls;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = spmcf_pkg::KIND_PUSH;
    in_ch.class_id  = '0;
    in_ch.item_data = '0;
    out_ch.ready    = 1'b0;
    push_pct  = 50;
    focus_cls = 0;
    focused   = 1'b0;
    idle_seg  = 1'b1;
    for (int c = 0; c < CLASSES; c++) begin
      mirror_rd[c]   = '0;
      mirror_wr[c]   = '0;
      mirror_fill[c] = '0;
    end

    // empty pop, priority order across classes, data extremes
    add_item(spmcf_pkg::KIND_POP, 0, '1, 0);
    add_item(spmcf_pkg::KIND_PUSH, 3, '1, 0);
    add_item(spmcf_pkg::KIND_PUSH, 2, '0, 2);
    add_item(spmcf_pkg::KIND_PUSH, 0, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    add_item(spmcf_pkg::KIND_POP, 3, 64'h5555_5555_5555_5555, 0);
    add_item(spmcf_pkg::KIND_POP, 1, '0, 1);
    add_item(spmcf_pkg::KIND_POP, 0, '1, 0);
    add_item(spmcf_pkg::KIND_POP, 2, '0, 3);
    // fill one class, then push into it while full
    for (int i = 0; i < DEPTH; i++)
      add_item(spmcf_pkg::KIND_PUSH, 1, 64'h8000_0000_0000_0000 | 64'(i),
               (i % 4 == 0) ? 1 : 0);
    add_item(spmcf_pkg::KIND_PUSH, 1, '1, 0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % SEG_LEN == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 10;
          1:       push_pct = 30;
          2:       push_pct = 50;
          3:       push_pct = 75;
          default: push_pct = 95;
        endcase
        focus_cls = $urandom_range(0, CLASSES - 1);
        focused   = $urandom_range(0, 1);
        idle_seg  = ($urandom_range(0, 3) != 0);
      end
      cls = (focused && $urandom_range(0, 3) != 0) ? focus_cls
                                                   : $urandom_range(0, (1 << PORT_CLASS_W) - 1);
      add_item(($urandom_range(1, 100) <= push_pct) ? spmcf_pkg::KIND_PUSH : spmcf_pkg::KIND_POP,
               cls, rand_word(), idle_seg ? $urandom_range(0, MAX_WAIT) : 0);
    end
    total_items = pending_items.size();

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (!(accepted_cnt == total_items && expected_results.size() == 0) &&
           cycle_cnt < CYCLE_LIMIT)
      @(posedge clk);
    if (cycle_cnt < CYCLE_LIMIT) repeat (DRAIN_CYCLES) @(posedge clk);
    else $display("timeout after %0d cycles", cycle_cnt);

    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      errors += expected_results.size();
    end
    if (cycle_cnt < CYCLE_LIMIT && errors == 0)
      $display("tb_strict_priority_multi_class_fifo OK");
    else
      $display("tb_strict_priority_multi_class_fifo NOT OK");
    $finish;
  end

endmodule
